// ===== src/rv64ws_pkg.sv =====
// Package with operation codes, request codes and shared types for the RV64 execute block.
`default_nettype none
package rv64ws_pkg;

  localparam int unsigned REG_COUNT_DEFAULT = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [4:0] WORD_SHIFT_MASK = 5'h1F;
  localparam logic [5:0] DWORD_SHIFT_MASK = 6'h3F;

  typedef enum logic [4:0] {
    OP_LWU    = 5'd0,
    OP_LD     = 5'd1,
    OP_SD     = 5'd2,
    OP_ADDIW  = 5'd3,
    OP_SLLIW  = 5'd4,
    OP_SRLIW  = 5'd5,
    OP_SRAIW  = 5'd6,
    OP_ADDW   = 5'd7,
    OP_SUBW   = 5'd8,
    OP_SLLW   = 5'd9,
    OP_SRLW   = 5'd10,
    OP_SRAW   = 5'd11,
    OP_SLLI   = 5'd12,
    OP_SRLI   = 5'd13,
    OP_SRAI   = 5'd14,
    OP_SLL    = 5'd15,
    OP_SRL    = 5'd16,
    OP_SRA    = 5'd17,
    OP_LDRET  = 5'd18
  } op_t;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Classes that the front end assigns.
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_LOAD  = 3'd1,
    CLS_STORE = 3'd2,
    CLS_ALU   = 3'd3,
    CLS_RET   = 3'd4
  } cls_t;

  typedef enum logic [2:0] {
    SH_LEFT  = 3'd0,
    SH_RIGHT = 3'd1,
    SH_ARITH = 3'd2,
    SH_ADD   = 3'd3,
    SH_SUB   = 3'd4
  } alu_fn_t;

  // Decoded request that travels through the queue.
  typedef struct packed {
    cls_t        cls;
    alu_fn_t     fn;
    logic        word;      // 32-bit result, sign-extended
    logic        use_imm;   // second operand is the shift amount or immediate
    logic        dword;     // load width
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [63:0] imm;       // sign-extended I/S immediate or shift amount
    logic [63:0] data;
  } dec_t;

endpackage : rv64ws_pkg
`default_nettype wire

// ===== src/rv64_word_shift_loadstore_exec.sv =====
// Top level of the RV64I word, shift and load/store execute block.
`default_nettype none
// This block executes the RV64I-only instructions (word add/subtract, word and
// doubleword shifts, LWU, LD, SD) against a 64-bit register file in which x0
// reads as zero. Every request yields exactly one result. A load issues a read
// request and remembers its destination; a later load-return request writes the
// returned doubleword, zero-extending the low word for LWU. The front end
// decodes each request into a two-entry queue, and the back end reads the
// register file, runs the adder and barrel shifter and registers the result.
// Throughput is one request per cycle while the result is taken. A request
// is written into a queue entry when it is accepted and later into the result
// register; a stalled result holds the back end and then the queue.
// Registers reset to zero through per-entry valid bits, so no clearing pass.
module rv64_word_shift_loadstore_exec
  import rv64ws_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT = REG_COUNT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_operation,
  input  wire logic [31:0] in_instruction_word,
  input  wire logic [63:0] in_returned_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_memory_request,
  output logic [63:0]      out_memory_address,
  output logic             out_access_is_doubleword,
  output logic [63:0]      out_store_value,
  output logic             out_register_written,
  output logic [4:0]       out_destination_index,
  output logic [63:0]      out_destination_value
);

  logic q_valid, q_ready;
  dec_t q_data;

  // Decode and queue.
  rv64ws_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_instruction_word,
    .in_returned_data, .q_valid, .q_ready, .q_data
  );

  // Execute and result register.
  rv64ws_back #(.REGISTER_COUNT(REGISTER_COUNT)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .out_valid, .out_ready,
    .out_memory_request, .out_memory_address, .out_access_is_doubleword,
    .out_store_value, .out_register_written, .out_destination_index,
    .out_destination_value
  );

endmodule : rv64_word_shift_loadstore_exec
`default_nettype wire

// ===== src/rv64ws_front.sv =====
// Front end: accepts requests, decodes them into classes and operand selects and queues them.
`default_nettype none
module rv64ws_front
  import rv64ws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_operation,
  input  wire logic [31:0] in_instruction_word,
  input  wire logic [63:0] in_returned_data,
  output logic             q_valid,
  input  wire logic        q_ready,
  output dec_t             q_data
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  dec_t             dec;
  dec_t             mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             push, pop;
  logic [31:0]      iw;
  logic [63:0]      imm_i, imm_s;

  assign iw = in_instruction_word;
  assign imm_i = {{52{iw[31]}}, iw[31:20]};
  assign imm_s = {{52{iw[31]}}, iw[31:25], iw[11:7]};

  always_comb begin
    dec = '0;
    dec.rd = iw[11:7];
    dec.rs1 = iw[19:15];
    dec.rs2 = iw[24:20];
    dec.data = in_returned_data;
    dec.cls = CLS_ALU;
    case (in_operation)
      OP_LWU, OP_LD: begin
        dec.cls = CLS_LOAD; dec.imm = imm_i; dec.dword = (in_operation == OP_LD);
      end
      OP_SD:    begin dec.cls = CLS_STORE; dec.imm = imm_s; end
      OP_ADDIW: begin dec.fn = SH_ADD; dec.word = 1'b1; dec.use_imm = 1'b1; dec.imm = imm_i; end
      OP_SLLIW, OP_SRLIW, OP_SRAIW: begin
        dec.word = 1'b1; dec.use_imm = 1'b1;
        dec.imm = {59'd0, iw[24:20] & WORD_SHIFT_MASK};
        dec.fn = (in_operation == OP_SLLIW) ? SH_LEFT :
                 (in_operation == OP_SRLIW) ? SH_RIGHT : SH_ARITH;
      end
      OP_ADDW:  begin dec.fn = SH_ADD; dec.word = 1'b1; end
      OP_SUBW:  begin dec.fn = SH_SUB; dec.word = 1'b1; end
      OP_SLLW:  begin dec.fn = SH_LEFT; dec.word = 1'b1; end
      OP_SRLW:  begin dec.fn = SH_RIGHT; dec.word = 1'b1; end
      OP_SRAW:  begin dec.fn = SH_ARITH; dec.word = 1'b1; end
      OP_SLLI, OP_SRLI, OP_SRAI: begin
        dec.use_imm = 1'b1;
        dec.imm = {58'd0, iw[25:20] & DWORD_SHIFT_MASK};
        dec.fn = (in_operation == OP_SLLI) ? SH_LEFT :
                 (in_operation == OP_SRLI) ? SH_RIGHT : SH_ARITH;
      end
      OP_SLL:   dec.fn = SH_LEFT;
      OP_SRL:   dec.fn = SH_RIGHT;
      OP_SRA:   dec.fn = SH_ARITH;
      OP_LDRET: dec.cls = CLS_RET;
      default:  dec.cls = CLS_NONE;
    endcase
  end

  assign in_ready = (cnt_r != (PW+1)'(QUEUE_DEPTH)) || q_ready;
  assign q_valid = (cnt_r != '0);
  assign q_data = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_comb begin
    wp_nxt = push ? PW'(wp_r + 1'b1) : wp_r;
    rp_nxt = pop ? PW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = PW'(0) + cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= dec;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !pop) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("count not advanced");

endmodule : rv64ws_front
`default_nettype wire

// ===== src/rv64ws_back.sv =====
// Back end: register file, adder, shifter and load tracking; registers one result.
`default_nettype none
module rv64ws_back
  import rv64ws_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT = REG_COUNT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  dec_t             q_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_memory_request,
  output logic [63:0]      out_memory_address,
  output logic             out_access_is_doubleword,
  output logic [63:0]      out_store_value,
  output logic             out_register_written,
  output logic [4:0]       out_destination_index,
  output logic [63:0]      out_destination_value
);

  logic [63:0] rf_r [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] vld_r;
  logic [4:0]  pend_rd_r;
  logic        pend_wu_r;
  logic        valid_r;
  logic [1:0]  req_r;
  logic [63:0] addr_r, sval_r, dval_r;
  logic        dw_r, wr_r;
  logic [4:0]  didx_r;

  logic [63:0] a, b, opb, sum, res, shin, sra_v;
  logic [5:0]  sh;
  logic [31:0] w32;
  logic [4:0]  target;
  logic        wen, fire;
  logic [1:0]  req;
  logic [63:0] addr, sval;
  logic        dw;

  function automatic logic [63:0] rd_reg(input logic [4:0] idx,
      input logic [63:0] v, input logic ok);
    rd_reg = (idx == 5'd0 || 32'(idx) >= REGISTER_COUNT || !ok) ? 64'd0 : v;
  endfunction

  logic [$clog2(REGISTER_COUNT)-1:0] i1, i2, it;
  assign i1 = q_data.rs1[$clog2(REGISTER_COUNT)-1:0];
  assign i2 = q_data.rs2[$clog2(REGISTER_COUNT)-1:0];
  assign it = target[$clog2(REGISTER_COUNT)-1:0];
  assign a = rd_reg(q_data.rs1, rf_r[i1], vld_r[i1]);
  assign b = rd_reg(q_data.rs2, rf_r[i2], vld_r[i2]);

  assign q_ready = !valid_r || out_ready;
  assign fire = q_valid && q_ready;

  always_comb begin
    opb = q_data.use_imm ? q_data.imm : b;
    sum = (q_data.fn == SH_SUB) ? a - opb : a + opb;
    sh = q_data.word ? {1'b0, opb[4:0]} : opb[5:0];
    shin = q_data.word ? ((q_data.fn == SH_ARITH) ? {{32{a[31]}}, a[31:0]}
                                                  : {32'd0, a[31:0]}) : a;
    sra_v = $unsigned($signed(shin) >>> sh);
    case (q_data.fn)
      SH_LEFT:  res = shin << sh;
      SH_RIGHT: res = shin >> sh;
      SH_ARITH: res = sra_v;
      default:  res = sum;
    endcase
    w32 = res[31:0];
    if (q_data.word) res = {{32{w32[31]}}, w32};
    req = REQ_NONE; addr = '0; dw = 1'b0; sval = '0;
    target = q_data.rd; wen = 1'b0;
    case (q_data.cls)
      CLS_LOAD:  begin req = REQ_READ; addr = a + q_data.imm; dw = q_data.dword; end
      CLS_STORE: begin req = REQ_WRITE; addr = a + q_data.imm; dw = 1'b1; sval = b; end
      CLS_ALU:   wen = 1'b1;
      CLS_RET: begin
        wen = 1'b1; target = pend_rd_r;
        res = pend_wu_r ? {32'd0, q_data.data[31:0]} : q_data.data;
      end
      default: ;
    endcase
    if (target == 5'd0 || 32'(target) >= REGISTER_COUNT) wen = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0; vld_r <= '0; pend_rd_r <= '0; pend_wu_r <= 1'b0;
    end else begin
      if (fire) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
      if (fire && wen) vld_r[it] <= 1'b1;
      if (fire && q_data.cls == CLS_LOAD) begin
        pend_rd_r <= q_data.rd; pend_wu_r <= !q_data.dword;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (wen) rf_r[it] <= res;
      req_r <= req; addr_r <= addr; dw_r <= dw; sval_r <= sval;
      wr_r <= wen; didx_r <= wen ? target : 5'd0; dval_r <= wen ? res : 64'd0;
    end
  end

  assign out_valid = valid_r;
  assign out_memory_request = req_r;
  assign out_memory_address = addr_r;
  assign out_access_is_doubleword = dw_r;
  assign out_store_value = sval_r;
  assign out_register_written = wr_r;
  assign out_destination_index = didx_r;
  assign out_destination_value = dval_r;

  a_x0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_register_written && out_destination_index == 5'd0))
    else $error("write to x0 reported");
  a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_register_written && out_memory_request != REQ_NONE))
    else $error("memory request and register write together");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule : rv64ws_back
`default_nettype wire

// ===== verif/rv64_exec_checker.sv =====
// Checker that predicts and compares the results of the RV64 execute block.
module rv64_exec_checker
  import rv64ws_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT = REG_COUNT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [4:0]  in_operation,
  input  wire logic [31:0] in_instruction_word,
  input  wire logic [63:0] in_returned_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_memory_request,
  input  wire logic [63:0] out_memory_address,
  input  wire logic        out_access_is_doubleword,
  input  wire logic [63:0] out_store_value,
  input  wire logic        out_register_written,
  input  wire logic [4:0]  out_destination_index,
  input  wire logic [63:0] out_destination_value,
  output int               fail_count,
  output int               pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  req;
    logic [63:0] addr;
    logic        dword;
    logic [63:0] sval;
    logic        wrote;
    logic [4:0]  rd;
    logic [63:0] value;
  } exec_result_t;

  logic [63:0]  gpr [32];
  logic [4:0]   load_rd;
  logic         load_lwu;
  exec_result_t expected_results [$];

  assign pending_results = expected_results.size();

  function automatic logic [63:0] read_gpr(logic [4:0] idx);
    if (idx == 0 || idx >= REGISTER_COUNT) return '0;
    return gpr[idx];
  endfunction

  function automatic logic [63:0] sext_word(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  // Computes the result of one request and updates the modeled state.
  function automatic exec_result_t execute_request(logic [4:0] op, logic [31:0] iw,
                                                   logic [63:0] data);
    exec_result_t r;
    logic [63:0] a, b, imm_i, imm_s, res;
    logic [4:0]  target;
    logic        writes;
    a      = read_gpr(iw[19:15]);
    b      = read_gpr(iw[24:20]);
    imm_i  = {{52{iw[31]}}, iw[31:20]};
    imm_s  = {{52{iw[31]}}, iw[31:25], iw[11:7]};
    r      = '0;
    res    = '0;
    target = iw[11:7];
    writes = 1'b1;
    case (op)
      OP_LWU, OP_LD: begin
        r.req    = REQ_READ;
        r.addr   = a + imm_i;
        r.dword  = (op == OP_LD);
        load_rd  = iw[11:7];
        load_lwu = (op == OP_LWU);
        writes   = 1'b0;
      end
      OP_SD: begin
        r.req   = REQ_WRITE;
        r.addr  = a + imm_s;
        r.dword = 1'b1;
        r.sval  = b;
        writes  = 1'b0;
      end
      OP_ADDIW: res = sext_word(a + imm_i);
      OP_SLLIW: res = sext_word({32'b0, a[31:0]} << iw[24:20]);
      OP_SRLIW: res = sext_word({32'b0, a[31:0]} >> iw[24:20]);
      OP_SRAIW: res = $signed(sext_word(a)) >>> iw[24:20];
      OP_ADDW:  res = sext_word(a + b);
      OP_SUBW:  res = sext_word(a - b);
      OP_SLLW:  res = sext_word({32'b0, a[31:0]} << b[4:0]);
      OP_SRLW:  res = sext_word({32'b0, a[31:0]} >> b[4:0]);
      OP_SRAW:  res = $signed(sext_word(a)) >>> b[4:0];
      OP_SLLI:  res = a << iw[25:20];
      OP_SRLI:  res = a >> iw[25:20];
      OP_SRAI:  res = $signed(a) >>> iw[25:20];
      OP_SLL:   res = a << b[5:0];
      OP_SRL:   res = a >> b[5:0];
      OP_SRA:   res = $signed(a) >>> b[5:0];
      OP_LDRET: begin
        target = load_rd;
        res    = load_lwu ? {32'b0, data[31:0]} : data;
      end
      default: writes = 1'b0;
    endcase
    if (writes && target != 0 && target < REGISTER_COUNT) begin
      gpr[target] = res;
      r.wrote = 1'b1;
      r.rd    = target;
      r.value = res;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    exec_result_t e;
    if (!rst_n) begin
      foreach (gpr[i]) gpr[i] = '0;
      load_rd  = '0;
      load_lwu = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("outstanding results", 64'd1, 64'd0);
        end else begin
          e = expected_results.pop_front();
          if (out_memory_request !== e.req)
            report_mismatch("memory_request", out_memory_request, e.req);
          if (out_memory_address !== e.addr)
            report_mismatch("memory_address", out_memory_address, e.addr);
          if (out_access_is_doubleword !== e.dword)
            report_mismatch("access_is_doubleword", out_access_is_doubleword, e.dword);
          if (out_store_value !== e.sval)
            report_mismatch("store_value", out_store_value, e.sval);
          if (out_register_written !== e.wrote)
            report_mismatch("register_written", out_register_written, e.wrote);
          if (out_destination_index !== e.rd)
            report_mismatch("destination_index", out_destination_index, e.rd);
          if (out_destination_value !== e.value)
            report_mismatch("destination_value", out_destination_value, e.value);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(execute_request(in_operation, in_instruction_word,
                                                   in_returned_data));
    end
  end
endmodule

// ===== verif/testbench.sv =====
// Top of the testbench: clock, reset, request stimulus and the verdict.
module testbench;
  import rv64ws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  in_operation = '0;
  logic [31:0] in_instruction_word = '0;
  logic [63:0] in_returned_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_memory_request;
  logic [63:0] out_memory_address;
  logic        out_access_is_doubleword;
  logic [63:0] out_store_value;
  logic        out_register_written;
  logic [4:0]  out_destination_index;
  logic [63:0] out_destination_value;
  int          fail_count;
  int          pending_results;

  // The sink side follows this mode: random bursts of back-pressure, a long
  // hold-off that lets the block fill up, or always ready near the end.
  bit          sink_quiet = 1'b0;
  bit          sink_hold = 1'b0;
  bit          sink_hold_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rv64_word_shift_loadstore_exec u_top (.*);

  rv64_exec_checker u_checker (.*);

  // Operations as a table, so random picks stay on named codes.
  op_t all_ops [19] = '{OP_LWU, OP_LD, OP_SD, OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW,
                        OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW, OP_SLLI, OP_SRLI,
                        OP_SRAI, OP_SLL, OP_SRL, OP_SRA, OP_LDRET};

  function automatic logic [63:0] rand_dword();
    logic [63:0] d;
    case ($urandom_range(0, 5))
      0: d = '0;
      1: d = '1;
      2: d = 64'h8000_0000_0000_0000;
      3: d = {32'h0, $urandom()} | 64'h8000_0000;
      default: d = {$urandom(), $urandom()};
    endcase
    return d;
  endfunction

  // Offers one request and holds it until the block takes it. A random idle
  // burst may come first when allow_idle is set.
  task automatic send_request(logic [4:0] op, logic [31:0] iw, logic [63:0] data,
                              bit allow_idle);
    int gap;
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_instruction_word <= iw;
    in_returned_data    <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic end_request();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sink back-pressure process.
  initial begin
    int burst;
    @(posedge clk iff rst_n);
    forever begin
      if (sink_quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (sink_hold) begin
        // Long hold-off so the queue fills and in_ready drops.
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        sink_hold      = 1'b0;
        sink_hold_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        burst = $urandom_range(1, 20);
        out_ready <= 1'b1;
        repeat (burst) @(posedge clk);
      end
    end
  end

  // Random instruction word that mostly touches the low registers, so
  // results are read back, and sometimes anything at all.
  function automatic logic [31:0] rand_instr();
    logic [31:0] iw;
    iw = $urandom();
    if ($urandom_range(0, 3) != 0) begin
      iw[11:7]  = $urandom_range(0, 7);
      iw[19:15] = $urandom_range(0, 7);
      if ($urandom_range(0, 1)) iw[24:20] = $urandom_range(0, 7);
    end
    return iw;
  endfunction

  initial begin
    logic [31:0] iw;
    logic [4:0]  op;
    int          n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: load registers with extremes, then every operation,
    // including an orphan load return, x0 as destination, bit 25 set on a
    // word shift by immediate, unused codes and extreme immediates.
    send_request(OP_LDRET, 32'h0, 64'hDEAD_BEEF_0123_4567, 0);
    send_request(OP_LD, {12'h0, 5'd0, 3'b0, 5'd1, 7'h0}, '0, 0);
    send_request(OP_LDRET, '0, 64'h8000_0000_FFFF_FFFF, 0);
    send_request(OP_LWU, {12'hFFF, 5'd1, 3'b0, 5'd2, 7'h0}, '0, 0);
    send_request(OP_LDRET, '0, 64'hFFFF_FFFF_8765_4321, 0);
    send_request(OP_LD, {12'h7FF, 5'd2, 3'b0, 5'd3, 7'h0}, '0, 0);
    send_request(OP_LDRET, '0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_request(OP_LD, {12'h800, 5'd3, 3'b0, 5'd4, 7'h0}, '0, 0);
    send_request(OP_LDRET, '0, 64'd63, 0);
    send_request(OP_SD, {7'h7F, 5'd3, 5'd1, 3'b011, 5'h1F, 7'h23}, '0, 0);
    send_request(OP_ADDIW, {12'h7FF, 5'd2, 3'b0, 5'd5, 7'h0}, '0, 0);
    send_request(OP_SLLIW, {7'h01, 5'd31, 5'd1, 3'b0, 5'd6, 7'h0}, '0, 0);
    send_request(OP_SRLIW, {7'h01, 5'd31, 5'd3, 3'b0, 5'd7, 7'h0}, '0, 0);
    send_request(OP_SRAIW, {7'h00, 5'd31, 5'd1, 3'b0, 5'd8, 7'h0}, '0, 0);
    send_request(OP_ADDW, {7'h0, 5'd3, 5'd1, 3'b0, 5'd9, 7'h0}, '0, 0);
    send_request(OP_SUBW, {7'h0, 5'd3, 5'd0, 3'b0, 5'd10, 7'h0}, '0, 0);
    send_request(OP_SLLW, {7'h0, 5'd4, 5'd1, 3'b0, 5'd11, 7'h0}, '0, 0);
    send_request(OP_SRLW, {7'h0, 5'd4, 5'd3, 3'b0, 5'd12, 7'h0}, '0, 0);
    send_request(OP_SRAW, {7'h0, 5'd4, 5'd1, 3'b0, 5'd13, 7'h0}, '0, 0);
    send_request(OP_SLLI, {6'h0, 6'd63, 5'd3, 3'b0, 5'd14, 7'h0}, '0, 0);
    send_request(OP_SRLI, {6'h0, 6'd63, 5'd3, 3'b0, 5'd15, 7'h0}, '0, 0);
    send_request(OP_SRAI, {6'h0, 6'd63, 5'd1, 3'b0, 5'd0, 7'h0}, '0, 0);
    send_request(OP_SLL, {7'h0, 5'd4, 5'd3, 3'b0, 5'd16, 7'h0}, '0, 0);
    send_request(OP_SRL, {7'h0, 5'd4, 5'd1, 3'b0, 5'd17, 7'h0}, '0, 0);
    send_request(OP_SRA, {7'h0, 5'd4, 5'd1, 3'b0, 5'd31, 7'h0}, '0, 0);
    send_request(5'd19, '1, '1, 0);
    send_request(5'd31, '1, '1, 0);

    // Pause the source until everything outstanding has drained.
    end_request();
    while (pending_results != 0) @(posedge clk);

    // Random part. Loads are mostly followed by their return so that the
    // destination gets written; stray returns and unused codes are noise.
    n = 0;
    while (n < 1900) begin
      if (n == 300) sink_hold = 1'b1;
      if (n == 1700) sink_quiet = 1'b1;
      iw = rand_instr();
      case ($urandom_range(0, 19))
        0:       op = 5'($urandom_range(19, 31));
        1, 2, 3: op = ($urandom_range(0, 1)) ? OP_LD : OP_LWU;
        default: op = all_ops[$urandom_range(2, 18)];
      endcase
      send_request(op, iw, rand_dword(), !sink_quiet);
      n++;
      if ((op == OP_LD || op == OP_LWU) && $urandom_range(0, 4) != 0) begin
        send_request(OP_LDRET, $urandom(), rand_dword(), !sink_quiet);
        n++;
      end
    end
    end_request();

    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && sink_hold_done)
      $display("[rv64_word_shift_loadstore_exec] OK");
    else
      $display("[rv64_word_shift_loadstore_exec] ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about 2000 requests.
  initial begin
    #10ms;
    $display("[rv64_word_shift_loadstore_exec] ERROR");
    $finish;
  end
endmodule
